>>> rtl/hilb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hilb_pkg: shared types, sizes and bit-level functions
// Sizes of the Hilbert index transform and the per-stage combinational
// steps. Covers the undo pass at one bit level and the final Gray, mask
// and interleave step.
// ----------------------------------------------------------------------------
package hilb_pkg;

  // Coordinate width and number of axes
  localparam int unsigned BITS  = 5;
  localparam int unsigned DIMS  = 3;
  // Index width and number of undo levels (bit BITS-1 down to bit 1)
  localparam int unsigned IDX_W = BITS * DIMS;
  localparam int unsigned NLVL  = BITS - 1;

  typedef logic [BITS-1:0]  axis_t;
  typedef axis_t [DIMS-1:0] axes_t;
  typedef logic [IDX_W-1:0] index_t;

  // Mask of all bits below bit position b
  function automatic axis_t low_mask(input int unsigned b);
    axis_t m;
    for (int unsigned p = 0; p < BITS; p++) begin
      m[p] = (p < b);
    end
    return m;
  endfunction

  // One level of the inverse undo pass: each axis in turn either inverts
  // the low bits of axis 0 or swaps its low bits with those of axis 0.
  function automatic axes_t undo_level(input axes_t a_in, input int unsigned b);
    axes_t a;
    axis_t low;
    axis_t t;
    a   = a_in;
    low = low_mask(b);
    for (int unsigned i = 0; i < DIMS; i++) begin
      if (a[i][b]) begin
        a[0] = a[0] ^ low;
      end else begin
        t    = (a[0] ^ a[i]) & low;
        a[0] = a[0] ^ t;
        a[i] = a[i] ^ t;
      end
    end
    return a;
  endfunction

  // Gray encode across axes, apply the correction mask from the last
  // axis, then interleave: top level first, axis 0 first within a level.
  function automatic index_t finish_index(input axes_t a_in);
    axes_t  a;
    axis_t  t;
    index_t idx;
    a = a_in;
    for (int unsigned i = 1; i < DIMS; i++) begin
      a[i] = a[i] ^ a[i-1];
    end
    t = '0;
    for (int unsigned b = 1; b < BITS; b++) begin
      if (a[DIMS-1][b]) begin
        t = t ^ low_mask(b);
      end
    end
    for (int unsigned i = 0; i < DIMS; i++) begin
      a[i] = a[i] ^ t;
    end
    for (int unsigned k = 0; k < BITS; k++) begin
      for (int unsigned i = 0; i < DIMS; i++) begin
        idx[k*DIMS + (DIMS-1-i)] = a[i][k];
      end
    end
    return idx;
  endfunction

endpackage

>>> rtl/hilbert_index_from_coords.sv
`timescale 1ns / 1ps
// Stages: one register per undo level (bit BITS-1 down to bit 1) plus the
//   output register.
// Throughput: one transaction per cycle while out_stall is low; each stage
//   advances when it is empty or its successor advances, so bubbles are squeezed out on stall.
// Reset: synchronous active-low rst_n clears all stage valid bits.
// ----------------------------------------------------------------------------
// hilbert_index_from_coords: Skilling axes-to-Hilbert-index transform
// Pipelined per bit level of the undo pass; the last stage does Gray
// encoding, the correction mask and the bit interleave.
// ----------------------------------------------------------------------------
module hilbert_index_from_coords (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [hilb_pkg::BITS-1:0]     in_coord_0,
  input  logic [hilb_pkg::BITS-1:0]     in_coord_1,
  input  logic [hilb_pkg::BITS-1:0]     in_coord_2,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [hilb_pkg::IDX_W-1:0]    out_hilbert_index
);

  localparam int unsigned NLVL = hilb_pkg::NLVL;

  // Stage registers: NLVL undo stages, then the output stage
  hilb_pkg::axes_t  ax_r  [NLVL];
  hilb_pkg::axes_t  ax_nxt[NLVL];
  hilb_pkg::index_t idx_r;
  hilb_pkg::index_t idx_nxt;
  logic [NLVL:0]    vld_r;
  logic [NLVL:0]    adv;
  hilb_pkg::axes_t  in_axes;

  assign in_axes[0] = in_coord_0;
  assign in_axes[1] = in_coord_1;
  assign in_axes[2] = in_coord_2;

  // Advance chain: a stage moves when empty or when its successor moves
  always_comb begin
    adv[NLVL] = !vld_r[NLVL] || !out_stall;
    for (int j = NLVL - 1; j >= 0; j--) begin
      adv[j] = !vld_r[j] || adv[j+1];
    end
  end

  assign in_stall = !adv[0];

  // Undo pass, one bit level per stage
  for (genvar j = 0; j < NLVL; j++) begin : g_lvl
    if (j == 0) begin : g_first
      assign ax_nxt[j] = hilb_pkg::undo_level(in_axes, NLVL - j);
    end else begin : g_rest
      assign ax_nxt[j] = hilb_pkg::undo_level(ax_r[j-1], NLVL - j);
    end

    always_ff @(posedge clk) begin
      if (adv[j]) begin
        ax_r[j] <= ax_nxt[j];
      end
    end
  end

  // Gray, correction mask and interleave
  assign idx_nxt = hilb_pkg::finish_index(ax_r[NLVL-1]);

  always_ff @(posedge clk) begin
    if (adv[NLVL]) begin
      idx_r <= idx_nxt;
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int j = 1; j <= int'(NLVL); j++) begin
        if (adv[j]) begin
          vld_r[j] <= vld_r[j-1];
        end
      end
    end
  end

  assign out_valid         = vld_r[NLVL];
  assign out_hilbert_index = idx_r;

  // Input is held off only when every stage is occupied
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&vld_r))
    else $error("input stalled with an empty pipeline stage");

  // The blocked first stage keeps its transaction
  a_hold_first: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[0] && !adv[0]) |=> (vld_r[0] && $stable(ax_r[0])))
    else $error("first stage lost or changed a stalled transaction");

  // A new result only comes from an occupied last undo stage
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(vld_r[NLVL-1]))
    else $error("result appeared without a source transaction");

  // Output held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[NLVL] && out_stall) |=> (vld_r[NLVL] && $stable(idx_r)))
    else $error("stalled result changed");

endmodule

>>> bench/tb_hilbert_index_from_coords.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hilbert_index_from_coords: self-checking bench for the Hilbert index block
// Drives 3-axis points through the valid/stall input channel and checks every
// returned index against an in-bench bit-level predictor, in order. Phases
// cover directed corners, random points under several idle/stall mixes, and
// a long output hold-off that backs the pipeline up to the input.
// ----------------------------------------------------------------------------
module tb_hilbert_index_from_coords;

  localparam int LATENCY = int'(hilb_pkg::BITS);

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  hilb_pkg::axis_t  in_coord_0 = '0;
  hilb_pkg::axis_t  in_coord_1 = '0;
  hilb_pkg::axis_t  in_coord_2 = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  hilb_pkg::index_t out_hilbert_index;

  hilb_pkg::index_t expected_index_q[$];
  int     error_count = 0;
  int     gap_pct = 0;
  int     stall_pct = 0;
  int     hold_req = 0;
  int     hold_left = 0;

  hilbert_index_from_coords uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_coord_0       (in_coord_0),
    .in_coord_1       (in_coord_1),
    .in_coord_2       (in_coord_2),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_hilbert_index(out_hilbert_index)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Skilling transform: undo pass, Gray encode, correction, interleave
  function automatic hilb_pkg::index_t compute_hilbert_index(input hilb_pkg::axis_t c0,
                                                             input hilb_pkg::axis_t c1,
                                                             input hilb_pkg::axis_t c2);
    hilb_pkg::axis_t  ax [hilb_pkg::DIMS];
    hilb_pkg::axis_t  low;
    hilb_pkg::axis_t  t;
    hilb_pkg::index_t idx;
    ax[0] = c0;
    ax[1] = c1;
    ax[2] = c2;
    for (int lv = hilb_pkg::BITS - 1; lv >= 1; lv--) begin
      low = hilb_pkg::axis_t'((1 << lv) - 1);
      for (int i = 0; i < hilb_pkg::DIMS; i++) begin
        if (ax[i][lv]) begin
          ax[0] = ax[0] ^ low;
        end else begin
          t     = (ax[0] ^ ax[i]) & low;
          ax[0] = ax[0] ^ t;
          ax[i] = ax[i] ^ t;
        end
      end
    end
    for (int i = 1; i < hilb_pkg::DIMS; i++) begin
      ax[i] = ax[i] ^ ax[i-1];
    end
    t = '0;
    for (int lv = hilb_pkg::BITS - 1; lv >= 1; lv--) begin
      if (ax[hilb_pkg::DIMS-1][lv]) begin
        t = t ^ hilb_pkg::axis_t'((1 << lv) - 1);
      end
    end
    for (int i = 0; i < hilb_pkg::DIMS; i++) begin
      ax[i] = ax[i] ^ t;
    end
    idx = '0;
    for (int k = hilb_pkg::BITS - 1; k >= 0; k--) begin
      for (int i = 0; i < hilb_pkg::DIMS; i++) begin
        idx = (idx << 1) | hilb_pkg::index_t'(ax[i][k]);
      end
    end
    return idx;
  endfunction

  // Receiver: random stall plus a counted hold-off on request
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Result checker: each output transaction against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_index_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d",
                 $realtime, out_hilbert_index);
        error_count++;
      end else begin
        if (out_hilbert_index !== expected_index_q[0]) begin
          $display("%0t: hilbert_index mismatch, expected %0d, actual %0d",
                   $realtime, expected_index_q[0], out_hilbert_index);
          error_count++;
        end
        void'(expected_index_q.pop_front());
      end
    end
  end

  // Offer one point, with random idle cycles first; returns once accepted
  task automatic send_point(input hilb_pkg::axis_t c0, input hilb_pkg::axis_t c1,
                            input hilb_pkg::axis_t c2);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_coord_0 <= c0;
    in_coord_1 <= c1;
    in_coord_2 <= c2;
    do begin
      @(posedge clk);
    end while (in_stall);
    expected_index_q.push_back(compute_hilbert_index(c0, c1, c2));
  endtask

  // Stop offering and wait until every expected result has come back
  task automatic wait_drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (expected_index_q.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    if (expected_index_q.size() != 0) begin
      $display("%0t: drain timed out with %0d results outstanding",
               $realtime, expected_index_q.size());
      error_count++;
    end
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  // Random axis value, biased a little toward the extremes
  function automatic hilb_pkg::axis_t rand_axis();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      return '0;
    end else if (sel == 1) begin
      return '1;
    end
    return hilb_pkg::axis_t'($urandom_range(0, (1 << hilb_pkg::BITS) - 1));
  endfunction

  task automatic run_random(input int count, input int gap, input int stall);
    gap_pct   = gap;
    stall_pct = stall;
    repeat (count) begin
      send_point(rand_axis(), rand_axis(), rand_axis());
    end
    wait_drain();
  endtask

  // Corners: all zeros/ones, single axes, alternating bits, one-hot levels
  task automatic test_directed();
    gap_pct   = 0;
    stall_pct = 0;
    send_point(5'd0,  5'd0,  5'd0);
    send_point(5'd31, 5'd31, 5'd31);
    send_point(5'd31, 5'd0,  5'd0);
    send_point(5'd0,  5'd31, 5'd0);
    send_point(5'd0,  5'd0,  5'd31);
    send_point(5'd31, 5'd31, 5'd0);
    send_point(5'd0,  5'd31, 5'd31);
    send_point(5'd31, 5'd0,  5'd31);
    send_point(5'd21, 5'd10, 5'd21);
    send_point(5'd10, 5'd21, 5'd10);
    send_point(5'd16, 5'd16, 5'd16);
    send_point(5'd1,  5'd1,  5'd1);
    send_point(5'd16, 5'd8,  5'd4);
    send_point(5'd1,  5'd2,  5'd4);
    send_point(5'd2,  5'd4,  5'd8);
    send_point(5'd15, 5'd15, 5'd15);
    send_point(5'd1,  5'd0,  5'd0);
    send_point(5'd0,  5'd1,  5'd0);
    send_point(5'd0,  5'd0,  5'd1);
    send_point(5'd30, 5'd29, 5'd27);
    wait_drain();
  endtask

  task automatic test_no_idle();
    run_random(320, 0, 0);
  endtask

  task automatic test_sender_idle();
    run_random(300, 68, 0);
  endtask

  task automatic test_receiver_stall();
    run_random(300, 0, 68);
  endtask

  task automatic test_both_idle();
    run_random(300, 15, 15);
  endtask

  // Long output hold-off while the sender keeps offering: pipeline fills
  task automatic test_backpressure();
    gap_pct   = 0;
    stall_pct = 0;
    hold_req  = 200;
    repeat (60) begin
      send_point(rand_axis(), rand_axis(), rand_axis());
    end
    wait_drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_no_idle();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    test_backpressure();
    repeat (LATENCY * 4) @(posedge clk);
    if (error_count == 0 && expected_index_q.size() == 0) begin
      $display("PASS hilbert_index_from_coords");
    end else begin
      $display("FAIL hilbert_index_from_coords");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("FAIL hilbert_index_from_coords");
    $finish;
  end

endmodule
